### rtl/core/mlbpe_pkg.sv
package mlbpe_pkg;

    localparam int LED_SLOTS = 9;
    localparam int NUM_LEDS_DEFAULT = 9;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 64;
    localparam int COUNT_W = 6;
    localparam int DUR_W = 16;
    localparam int TIME_W = 32;

    typedef enum logic [0:0] {
        OP_UPDATE  = 1'b0,
        OP_STARTUP = 1'b1
    } opcode_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNTS    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ON_LO     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ON_HI     = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFF_LO    = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFF_HI    = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_LED  = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_STARTUP   = 8'd7;

    // per-lane strobes for the current request
    typedef struct packed {
        logic step;
        logic force_on;
        logic force_off;
    } lane_ctrl_t;

    // pick a 16-bit duration: lanes 0..3 from lo, 4..7 from hi, lane 8 from last
    function automatic logic [DUR_W-1:0] lane_duration(
        input logic [3:0]  idx,
        input logic [63:0] lo,
        input logic [63:0] hi,
        input logic [15:0] last
    );
        logic [DUR_W-1:0] d;
        if (idx < 4'd4) begin
            d = lo[{idx[1:0], 4'b0000} +: DUR_W];
        end else if (idx < 4'd8) begin
            d = hi[{idx[1:0], 4'b0000} +: DUR_W];
        end else begin
            d = last;
        end
        return d;
    endfunction

endpackage

### rtl/core/mlbpe_lane.sv
module mlbpe_lane
    import mlbpe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  lane_ctrl_t         ctrl,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic               enable,
    input  logic               continuous,
    input  logic [COUNT_W-1:0] count,
    input  logic [DUR_W-1:0]   on_time,
    input  logic [DUR_W-1:0]   off_time,
    output logic               pin_next
);

    logic               pin_reg, lit_reg, run_reg;
    logic               lit_next, run_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [TIME_W-1:0]  phase_reg, phase_next;

    logic               pin_in;
    logic [TIME_W-1:0]  elapsed;
    logic [DUR_W-1:0]   dur;
    logic               expired;
    logic [COUNT_W:0]   cnt_inc;
    logic               endless;

    assign pin_in  = ctrl.force_off ? 1'b0 : pin_reg;
    assign elapsed = now_ms - phase_reg;
    assign dur     = lit_reg ? on_time : off_time;
    assign expired = elapsed >= {{(TIME_W-DUR_W){1'b0}}, dur};
    assign cnt_inc = {1'b0, cnt_reg} + {{COUNT_W{1'b0}}, 1'b1};
    assign endless = (count == '0);

    always_comb begin
        pin_next   = pin_in;
        lit_next   = lit_reg;
        run_next   = run_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        if (ctrl.force_on) begin
            pin_next = 1'b1;
        end else if (ctrl.step) begin
            priority if (continuous) begin
                if (!enable) begin
                    pin_next   = 1'b0;
                    lit_next   = 1'b0;
                    run_next   = 1'b0;
                    cnt_next   = '0;
                    phase_next = '0;
                end else if (!lit_reg) begin
                    pin_next = 1'b1;
                    lit_next = 1'b1;
                end
            end else if (!endless && enable && !run_reg) begin
                cnt_next   = '0;
                run_next   = 1'b1;
                lit_next   = 1'b1;
                phase_next = now_ms;
                pin_next   = 1'b1;
            end else if (!endless && run_reg) begin
                if (expired) begin
                    phase_next = now_ms;
                    if (lit_reg) begin
                        pin_next = 1'b0;
                        lit_next = 1'b0;
                    end else if (cnt_inc >= {1'b0, count}) begin
                        pin_next   = 1'b0;
                        lit_next   = 1'b0;
                        run_next   = 1'b0;
                        cnt_next   = '0;
                        phase_next = '0;
                    end else begin
                        cnt_next = cnt_inc[COUNT_W-1:0];
                        pin_next = 1'b1;
                        lit_next = 1'b1;
                    end
                end
            end else if (endless) begin
                if (!enable) begin
                    pin_next   = 1'b0;
                    lit_next   = 1'b0;
                    run_next   = 1'b0;
                    cnt_next   = '0;
                    phase_next = '0;
                end else if (!run_reg) begin
                    cnt_next   = '0;
                    run_next   = 1'b1;
                    lit_next   = 1'b1;
                    phase_next = now_ms;
                    pin_next   = 1'b1;
                end else if (expired) begin
                    phase_next = now_ms;
                    pin_next   = !lit_reg;
                    lit_next   = !lit_reg;
                end
            end else begin
                pin_next = pin_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_reg   <= 1'b0;
            lit_reg   <= 1'b0;
            run_reg   <= 1'b0;
            cnt_reg   <= '0;
            phase_reg <= '0;
        end else begin
            pin_reg   <= pin_next;
            lit_reg   <= lit_next;
            run_reg   <= run_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

endmodule

### rtl/core/multi_led_blink_pattern_engine.sv
// An accepted request's result is written into the output register. One request is
// taken per cycle unless the output register holds data and m_ready is low; every
// LED lane updates in parallel (one 32-bit subtract and compare per lane sets the
// clock path). A new request is taken while the output register drains to the
// consumer. Reset (aresetn, synchronous, active low): config registers, LED state,
// start-up flash state and the output register are cleared.
module multi_led_blink_pattern_engine
    import mlbpe_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_opcode,
    input  logic [TIME_W-1:0]      s_now_ms,
    input  logic [LED_SLOTS-1:0]   s_enable_mask,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LED_SLOTS-1:0]   m_led_levels,
    output logic                   m_builtin_led
);

    logic [LED_SLOTS-1:0]           mode_reg;
    logic [LED_SLOTS*COUNT_W-1:0]   counts_reg;
    logic [63:0]                    on_lo_reg, on_hi_reg, off_lo_reg, off_hi_reg;
    logic [31:0]                    last_reg;
    logic [DUR_W-1:0]               startup_reg;

    logic                           flash_run_reg, flash_run_next;
    logic [TIME_W-1:0]              flash_begin_reg, flash_begin_next;
    logic                           builtin_reg, builtin_next;

    logic                           m_valid_reg;
    logic [LED_SLOTS-1:0]           m_levels_reg;
    logic                           m_builtin_reg;

    logic                           accept, start_req, update_req;
    logic                           hold, flash_end;
    logic [TIME_W-1:0]              flash_elapsed;
    lane_ctrl_t                     lane_ctrl;
    logic [LED_SLOTS-1:0]           pin_vec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= '0;
            counts_reg  <= '0;
            on_lo_reg   <= '0;
            on_hi_reg   <= '0;
            off_lo_reg  <= '0;
            off_hi_reg  <= '0;
            last_reg    <= '0;
            startup_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MODE:     mode_reg    <= cfg_data[LED_SLOTS-1:0];
                CFG_COUNTS:   counts_reg  <= cfg_data[LED_SLOTS*COUNT_W-1:0];
                CFG_ON_LO:    on_lo_reg   <= cfg_data;
                CFG_ON_HI:    on_hi_reg   <= cfg_data;
                CFG_OFF_LO:   off_lo_reg  <= cfg_data;
                CFG_OFF_HI:   off_hi_reg  <= cfg_data;
                CFG_LAST_LED: last_reg    <= cfg_data[31:0];
                CFG_STARTUP:  startup_reg <= cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign start_req  = accept && (opcode_t'(s_opcode) == OP_STARTUP);
    assign update_req = accept && (opcode_t'(s_opcode) == OP_UPDATE);

    assign flash_elapsed = s_now_ms - flash_begin_reg;
    assign hold = flash_run_reg &&
                  (flash_elapsed < {{(TIME_W-DUR_W){1'b0}}, startup_reg});
    assign flash_end = update_req && flash_run_reg && !hold;

    always_comb begin
        lane_ctrl.step      = update_req && !hold;
        lane_ctrl.force_on  = start_req;
        lane_ctrl.force_off = flash_end;

        flash_run_next   = flash_run_reg;
        flash_begin_next = flash_begin_reg;
        builtin_next     = builtin_reg;
        if (start_req) begin
            flash_run_next   = 1'b1;
            flash_begin_next = s_now_ms;
            builtin_next     = 1'b1;
        end else if (flash_end) begin
            flash_run_next = 1'b0;
            builtin_next   = 1'b0;
        end
    end

    for (genvar gi = 0; gi < LED_SLOTS; gi++) begin : g_lane
        if (gi < NUM_LEDS) begin : g_on
            mlbpe_lane u_lane (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (lane_ctrl),
                .now_ms     (s_now_ms),
                .enable     (s_enable_mask[gi]),
                .continuous (mode_reg[gi]),
                .count      (counts_reg[gi*COUNT_W +: COUNT_W]),
                .on_time    (lane_duration(4'(gi), on_lo_reg, on_hi_reg, last_reg[15:0])),
                .off_time   (lane_duration(4'(gi), off_lo_reg, off_hi_reg, last_reg[31:16])),
                .pin_next   (pin_vec[gi])
            );
        end else begin : g_off
            assign pin_vec[gi] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flash_run_reg   <= 1'b0;
            flash_begin_reg <= '0;
            builtin_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            m_levels_reg    <= '0;
            m_builtin_reg   <= 1'b0;
        end else begin
            flash_run_reg   <= flash_run_next;
            flash_begin_reg <= flash_begin_next;
            builtin_reg     <= builtin_next;
            if (accept) begin
                m_valid_reg   <= 1'b1;
                m_levels_reg  <= pin_vec;
                m_builtin_reg <= builtin_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_led_levels  = m_levels_reg;
    assign m_builtin_led = m_builtin_reg;

endmodule
